### rtl/core/fvsl_pkg.sv
// ----------------------------------------------------------------------------
// fvsl_pkg
// Types, widths and codes shared by the force vector slew limiter modules.
// ----------------------------------------------------------------------------
package fvsl_pkg;

    // Working component: holds scaled vectors and unit directions.
    localparam int COMP_W = 18;
    // Magnitudes in units of 2^-4 of an input LSB.
    localparam int MAG_W  = 22;
    // Accumulator for sums of squares and dot products.
    localparam int ACC_W  = 48;
    // Shared multiplier operand and product widths.
    localparam int MOP_W  = 25;
    localparam int PROD_W = 2 * MOP_W;
    // Divider numerator magnitude.
    localparam int NUM_W  = 40;
    // Square root radicand and root.
    localparam int RAD_W  = 46;
    localparam int ROOT_W = RAD_W / 2;
    // Blended norm width.
    localparam int BN_W   = 17;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic        [MAG_W-1:0]  t_mag;
    typedef logic signed [15:0]       t_word;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_INC = 2'd0,
        CFG_COS = 2'd1,
        CFG_WGT = 2'd2,
        CFG_MAX = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_ROOT,
        ST_RWAIT,
        ST_GROW,
        ST_VMUL,
        ST_VSTART,
        ST_VWAIT,
        ST_DOT,
        ST_DOTCMP,
        ST_BLEND,
        ST_FIN
    } t_state;

    // Which magnitude a sum of squares is computing.
    typedef enum logic [2:0] {
        SQ_P,
        SQ_C,
        SQ_M,
        SQ_B,
        SQ_H
    } t_qsel;

    // Which per-component division job is running.
    typedef enum logic [2:0] {
        VD_S1,
        VD_CU,
        VD_LU,
        VD_S2,
        VD_S3
    } t_vsel;

    // Request to the divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        t_mag             den;
    } t_div_req;

    // Request to the square root unit.
    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] rad;
    } t_sqrt_req;

    // Status from an iterative unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // Saturate a working component to a 16-bit word.
    function automatic t_word sat16(input t_comp a);
        t_word r;
        if (a > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (a < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = a[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/fvsl_div.sv
// ----------------------------------------------------------------------------
// fvsl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fvsl_div
    import fvsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_unit_sts        o_sts,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    t_mag             r_den;
    t_mag             r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [MAG_W:0] rem2;
    logic [MAG_W:0] diff;
    logic           ge;

    // One trial subtraction per cycle.
    always_comb begin
        rem2 = {r_rem, r_num[NUM_W-1]};
        diff = rem2 - {1'b0, r_den};
        ge   = (rem2 >= {1'b0, r_den});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the numerator shifts out.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_num;

endmodule

### rtl/core/fvsl_sqrt.sv
// ----------------------------------------------------------------------------
// fvsl_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module fvsl_sqrt
    import fvsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sqrt_req         i_req,
    output t_unit_sts         o_sts,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             ge;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial = (REM_W + 2)'({r_root, 2'b01});
        ge    = (rem2 >= trial);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

### rtl/core/force_vector_slew_limiter.sv
// ----------------------------------------------------------------------------
// force_vector_slew_limiter
// Slew limiter for a 3-D haptic force vector: limits magnitude growth,
// softens sudden turns by blending directions, and clamps the magnitude.
//
//   channel   | signals                              | direction
//   ----------+--------------------------------------+----------
//   input     | i_valid, o_stall, i_raw_x/y/z        | in
//   output    | o_valid, i_stall, o_smooth_x/y/z     | out
//   config    | i_cfg_we, i_cfg_idx, i_cfg_data      | in
//
// One word passes from acceptance to the output register through the shared
// divider (up to 15 divisions, each skipped for a zero divisor) and the
// square root unit (4 or 5 roots, each after its sum of squares).
// Only one word is in flight; o_stall is high from acceptance until the
// result has been placed in the output register.
// The output register holds a result while i_stall is high, and the next
// word may be accepted meanwhile. Reset is synchronous and clears the previous
// output to zero and the configuration and control registers to their defaults.
// ----------------------------------------------------------------------------
module force_vector_slew_limiter
    import fvsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_x,
    input  logic [15:0] i_raw_y,
    input  logic [15:0] i_raw_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_smooth_x,
    output logic [15:0] o_smooth_y,
    output logic [15:0] o_smooth_z,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam logic [1:0] IDX_LAST = 2'd2;
    localparam logic signed [MOP_W-1:0] UNIT_SCALE = MOP_W'(1 << 20);

    // Configuration registers.
    logic [15:0] r_inc;
    logic [15:0] r_cos;
    logic [15:0] r_wgt;
    logic [14:0] r_max;

    // Sequencer and datapath registers.
    t_state                   r_state, n_state;
    logic [1:0]               r_idx, n_idx;
    logic [1:0]               r_ph, n_ph;
    t_qsel                    r_qsel, n_qsel;
    t_vsel                    r_vsel, n_vsel;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod;
    t_comp                    r_v [3];
    t_comp                    n_v [3];
    t_comp                    r_cu [3];
    t_comp                    n_cu [3];
    t_comp                    r_lu [3];
    t_comp                    n_lu [3];
    t_word                    r_prev [3];
    t_word                    n_prev [3];
    t_word                    r_out [3];
    t_word                    n_out [3];
    t_mag                     r_lmag, n_lmag;
    t_mag                     r_cmag, n_cmag;
    t_mag                     r_m, n_m;
    t_mag                     r_t, n_t;
    logic [BN_W-1:0]          r_bn, n_bn;
    logic                     r_neg, n_neg;
    logic                     r_ovalid, n_ovalid;

    // Shared arithmetic unit interfaces.
    logic signed [MOP_W-1:0]  mul_a, mul_b;
    t_div_req                 dv_req;
    t_unit_sts                dv_sts;
    logic [NUM_W-1:0]         dv_quo;
    t_sqrt_req                sq_req;
    t_unit_sts                sq_sts;
    logic [ROOT_W-1:0]        sq_root;

    // Combinational helpers.
    t_comp                    sq_op;
    t_comp                    vd_op;
    t_comp                    vd_res;
    t_comp                    dv_q;
    logic                     vd_write;
    t_mag                     vd_den;
    t_mag                     lim;
    t_mag                     root_mag;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [PROD_W-1:0] grow_lhs;
    logic signed [PROD_W-1:0] bl_sum;
    logic signed [PROD_W-1:0] bl_q;

    fvsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dv_req),
        .o_sts   (dv_sts),
        .o_quo   (dv_quo)
    );

    fvsl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_sts   (sq_sts),
        .o_root  (sq_root)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= 16'd9830;
            r_cos <= 16'd64881;
            r_wgt <= 16'd58982;
            r_max <= 15'd4915;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INC: r_inc <= i_cfg_data;
                CFG_COS: r_cos <= i_cfg_data;
                CFG_WGT: r_wgt <= i_cfg_data;
                CFG_MAX: r_max <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Operand selection shared by several states.
    always_comb begin
        lim      = MAG_W'({r_max, 4'b0000});
        root_mag = sq_root[MAG_W-1:0];
        prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
        dv_q     = dv_quo[COMP_W-1:0];
        grow_lhs = (PROD_W'($signed({1'b0, r_cmag})) - PROD_W'($signed({1'b0, r_lmag})))
                   <<< 16;
        bl_sum   = PROD_W'(r_acc) + r_prod;
        bl_q     = bl_sum[PROD_W-1] ? -((-bl_sum) >>> 16) : (bl_sum >>> 16);

        case (r_qsel)
            SQ_P:    sq_op = COMP_W'(r_prev[r_idx]);
            SQ_B:    sq_op = r_cu[r_idx];
            default: sq_op = r_v[r_idx];
        endcase

        case (r_vsel)
            VD_LU:   vd_op = COMP_W'(r_prev[r_idx]);
            VD_S2:   vd_op = r_cu[r_idx];
            default: vd_op = r_v[r_idx];
        endcase

        case (r_vsel)
            VD_S1:   vd_den = r_cmag;
            VD_LU:   vd_den = r_lmag;
            VD_S2:   vd_den = MAG_W'({r_bn, 4'b0000});
            default: vd_den = r_m;
        endcase
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ph     = r_ph;
        n_qsel   = r_qsel;
        n_vsel   = r_vsel;
        n_acc    = r_acc;
        n_v      = r_v;
        n_cu     = r_cu;
        n_lu     = r_lu;
        n_prev   = r_prev;
        n_out    = r_out;
        n_lmag   = r_lmag;
        n_cmag   = r_cmag;
        n_m      = r_m;
        n_t      = r_t;
        n_bn     = r_bn;
        n_neg    = r_neg;
        n_ovalid = r_ovalid;
        mul_a    = '0;
        mul_b    = '0;
        dv_req   = '{start: 1'b0, num: prod_abs[NUM_W-1:0], den: vd_den};
        sq_req   = '{start: 1'b0, rad: '0};
        vd_write = 1'b0;
        vd_res   = '0;

        // The output word leaves when the far side takes it.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_v[0]  = COMP_W'($signed(i_raw_x));
                    n_v[1]  = COMP_W'($signed(i_raw_y));
                    n_v[2]  = COMP_W'($signed(i_raw_z));
                    n_qsel  = SQ_P;
                    n_idx   = '0;
                    n_ph    = '0;
                    n_acc   = '0;
                    n_state = ST_SUMSQ;
                end
            end

            // Sum of squares of the selected vector.
            ST_SUMSQ: begin
                if (r_ph == 2'd0) begin
                    mul_a = MOP_W'(sq_op);
                    mul_b = MOP_W'(sq_op);
                    n_ph  = 2'd1;
                end else begin
                    n_acc = r_acc + r_prod[ACC_W-1:0];
                    n_ph  = 2'd0;
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_state = ST_ROOT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end

            // Magnitudes are scaled by 256 under the root; the blend norm is not.
            ST_ROOT: begin
                sq_req.start = 1'b1;
                if (r_qsel == SQ_B) begin
                    sq_req.rad = RAD_W'(r_acc[RAD_W-9:0]);
                end else begin
                    sq_req.rad = {r_acc[RAD_W-9:0], 8'h00};
                end
                n_state = ST_RWAIT;
            end

            ST_RWAIT: begin
                if (sq_sts.done) begin
                    n_idx = '0;
                    n_ph  = '0;
                    n_acc = '0;
                    case (r_qsel)
                        SQ_P: begin
                            n_lmag  = root_mag;
                            n_qsel  = SQ_C;
                            n_state = ST_SUMSQ;
                        end
                        SQ_C: begin
                            n_cmag  = root_mag;
                            n_state = ST_GROW;
                        end
                        SQ_M: begin
                            n_m     = root_mag;
                            n_vsel  = VD_CU;
                            n_state = ST_VMUL;
                        end
                        SQ_B: begin
                            n_bn = sq_root[BN_W-1:0];
                            if (sq_root == '0) begin
                                n_v[0]  = '0;
                                n_v[1]  = '0;
                                n_v[2]  = '0;
                                n_qsel  = SQ_H;
                                n_state = ST_SUMSQ;
                            end else begin
                                n_vsel  = VD_S2;
                                n_state = ST_VMUL;
                            end
                        end
                        default: begin
                            n_m = root_mag;
                            if (root_mag > lim) begin
                                n_vsel  = VD_S3;
                                n_state = ST_VMUL;
                            end else begin
                                n_state = ST_FIN;
                            end
                        end
                    endcase
                end
            end

            // Growth test against the allowed increase.
            ST_GROW: begin
                if (r_ph == 2'd0) begin
                    mul_a = $signed(MOP_W'(r_cmag));
                    mul_b = $signed(MOP_W'(r_inc));
                    n_ph  = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if ((grow_lhs > r_prod) && (r_cmag != '0)) begin
                        n_t     = r_lmag + r_prod[MAG_W+15:16];
                        n_vsel  = VD_S1;
                        n_state = ST_VMUL;
                    end else begin
                        n_qsel  = SQ_M;
                        n_state = ST_SUMSQ;
                    end
                end
            end

            // Per-component product before division.
            ST_VMUL: begin
                mul_a = MOP_W'(vd_op);
                case (r_vsel)
                    VD_S1:   mul_b = $signed(MOP_W'(r_t));
                    VD_S2:   mul_b = $signed(MOP_W'(r_m));
                    VD_S3:   mul_b = $signed(MOP_W'(lim));
                    default: mul_b = UNIT_SCALE;
                endcase
                n_state = ST_VSTART;
            end

            // A zero divisor gives a zero component.
            ST_VSTART: begin
                if (vd_den == '0) begin
                    vd_write = 1'b1;
                end else begin
                    dv_req.start = 1'b1;
                    n_neg        = r_prod[PROD_W-1];
                    n_state      = ST_VWAIT;
                end
            end

            ST_VWAIT: begin
                if (dv_sts.done) begin
                    vd_write = 1'b1;
                    vd_res   = r_neg ? -dv_q : dv_q;
                end
            end

            // Cosine between the new and old directions.
            ST_DOT: begin
                if (r_ph == 2'd0) begin
                    mul_a = MOP_W'(r_cu[r_idx]);
                    mul_b = MOP_W'(r_lu[r_idx]);
                    n_ph  = 2'd1;
                end else begin
                    n_acc = r_acc + r_prod[ACC_W-1:0];
                    n_ph  = 2'd0;
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_state = ST_DOTCMP;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end

            ST_DOTCMP: begin
                n_idx = '0;
                n_ph  = '0;
                if (r_acc < $signed({16'h0000, r_cos, 16'h0000})) begin
                    n_state = ST_BLEND;
                end else begin
                    n_acc   = '0;
                    n_qsel  = SQ_H;
                    n_state = ST_SUMSQ;
                end
            end

            // Weighted blend of old and new directions, kept in the cu registers.
            ST_BLEND: begin
                case (r_ph)
                    2'd0: begin
                        mul_a = $signed(MOP_W'(r_wgt));
                        mul_b = MOP_W'(r_lu[r_idx]);
                        n_ph  = 2'd1;
                    end
                    2'd1: begin
                        n_acc = r_prod[ACC_W-1:0];
                        mul_a = $signed(MOP_W'(17'h10000 - {1'b0, r_wgt}));
                        mul_b = MOP_W'(r_cu[r_idx]);
                        n_ph  = 2'd2;
                    end
                    default: begin
                        n_cu[r_idx] = bl_q[COMP_W-1:0];
                        n_ph        = 2'd0;
                        if (r_idx == IDX_LAST) begin
                            n_idx   = '0;
                            n_acc   = '0;
                            n_qsel  = SQ_B;
                            n_state = ST_SUMSQ;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                endcase
            end

            // Hand the word to the output register once it is free.
            ST_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    for (int k = 0; k < 3; k++) begin
                        n_out[k]  = sat16(r_v[k]);
                        n_prev[k] = sat16(r_v[k]);
                    end
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        // Store a divided component and move to the next one or the next job.
        if (vd_write) begin
            case (r_vsel)
                VD_CU:   n_cu[r_idx] = vd_res;
                VD_LU:   n_lu[r_idx] = vd_res;
                default: n_v[r_idx]  = vd_res;
            endcase
            if (r_idx == IDX_LAST) begin
                n_idx = '0;
                n_ph  = '0;
                n_acc = '0;
                case (r_vsel)
                    VD_S1: begin
                        n_qsel  = SQ_M;
                        n_state = ST_SUMSQ;
                    end
                    VD_CU: begin
                        n_vsel  = VD_LU;
                        n_state = ST_VMUL;
                    end
                    VD_LU:   n_state = ST_DOT;
                    VD_S2: begin
                        n_qsel  = SQ_H;
                        n_state = ST_SUMSQ;
                    end
                    default: n_state = ST_FIN;
                endcase
            end else begin
                n_idx   = r_idx + 2'd1;
                n_state = ST_VMUL;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_ph     <= '0;
            r_qsel   <= SQ_P;
            r_vsel   <= VD_S1;
            r_ovalid <= 1'b0;
            r_prev   <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ph     <= n_ph;
            r_qsel   <= n_qsel;
            r_vsel   <= n_vsel;
            r_ovalid <= n_ovalid;
            r_prev   <= n_prev;
        end
    end

    // Datapath registers and the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_acc  <= n_acc;
        r_v    <= n_v;
        r_cu   <= n_cu;
        r_lu   <= n_lu;
        r_out  <= n_out;
        r_lmag <= n_lmag;
        r_cmag <= n_cmag;
        r_m    <= n_m;
        r_t    <= n_t;
        r_bn   <= n_bn;
        r_neg  <= n_neg;
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_smooth_x = r_out[0];
    assign o_smooth_y = r_out[1];
    assign o_smooth_z = r_out[2];

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_req.start |-> (dv_req.den != '0))
        else $error("divider started with zero divisor");

    // No iterative unit is left running while the block waits for a word.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!dv_sts.busy && !sq_sts.busy))
        else $error("unit busy while idle");

    // The word on offer is the one kept as the previous output.
    a_out_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out[0] == r_prev[0] && r_out[1] == r_prev[1] &&
                      r_out[2] == r_prev[2]))
        else $error("output word differs from stored previous output");

    // An accepted word starts the previous-magnitude sum.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_SUMSQ && r_qsel == SQ_P))
        else $error("accepted word did not start processing");

    // The component index stays within the vector.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("component index out of range");

endmodule
